### sv/svalloc_pkg.sv
// shared types, constants and codes for the synth voice allocator
`timescale 1ns / 1ps

package svalloc_pkg;

   localparam int MAX_VOICES_DEF = 18;
   localparam int TIME_BITS_DEF  = 32;

   localparam int REQ_W      = 2;
   localparam int CH_W       = 4;
   localparam int NOTE_W     = 7;
   localparam int KIND_W     = 3;
   localparam int VIDX_OUT_W = 5;
   localparam int ACT_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int MAX_RESULTS = 18;
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [NOTE_W-1:0] PERC_LOW   = 7'd35;
   localparam logic [NOTE_W-1:0] PERC_HIGH  = 7'd81;
   localparam logic [CH_W-1:0]   PERC_RESET = 4'd15;
   localparam logic [ACT_W-1:0]  ACT_RESET  = 5'd18;

   typedef enum logic [0:0] {
      REG_PERC   = 1'b0,
      REG_ACTIVE = 1'b1
   } reg_idx_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_NOTE_ON  = 2'd0,
      REQ_NOTE_OFF = 2'd1,
      REQ_TOUCH    = 2'd2,
      REQ_TICK     = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      EV_PRIMARY   = 3'd0,
      EV_SECONDARY = 3'd1,
      EV_RELEASED  = 3'd2,
      EV_STOLEN    = 3'd3,
      EV_TOUCHED   = 3'd4,
      EV_REFUSED   = 3'd5
   } ev_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_STEAL,
      ST_KILL,
      ST_OCCUPY,
      ST_MATCH,
      ST_REFUSE,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      TBL_NOP,
      TBL_FREE,
      TBL_OCCUPY,
      TBL_TOUCH
   } tbl_op_type;

   typedef struct packed {
      logic              busy;
      logic [CH_W-1:0]   owner;
      logic [NOTE_W-1:0] key;
      logic              sec;
   } slot_type;

   typedef struct packed {
      tbl_op_type        op;
      logic [CH_W-1:0]   owner;
      logic [NOTE_W-1:0] key;
      logic              sec;
   } tbl_wr_type;

   typedef struct packed {
      logic [CH_W-1:0]   ch;
      logic [NOTE_W-1:0] note;
      logic              touch;
   } eval_ctx_type;

   typedef struct packed {
      logic free;
      logic match;
      logic sec;
      logic older;
   } eval_type;

   typedef struct packed {
      ev_kind_type           kind;
      logic [VIDX_OUT_W-1:0] vidx;
      logic [CH_W-1:0]       ch;
      logic [NOTE_W-1:0]     note;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic finish;
   } rb_ctl_type;

   typedef struct packed {
      logic push_ok;
      logic finish_done;
   } rb_stat_type;

endpackage

### sv/synth_voice_allocator.sv
// top level of the synth voice allocator: register port, sequencer, table, result buffer
//
//  channel   ports   handshake            beat
//  request   req_    req_valid/req_ready  one music event
//  response  rsp_    rsp_valid/rsp_ready  one voice event, rsp_last_result on the final one
//  config    csr_    apb write/read       percussion channel, active voice count
//
// one voice table slot is judged per cycle by the shared compare unit unless a beat stalls
// reset clears the whole voice table at once, so no clearing pass follows it
// the request side is ready only between events; a stalled response holds the scan only
// when a second beat is waiting behind the pending one
`timescale 1ns / 1ps

module synth_voice_allocator #(
   parameter int MAX_VOICES = svalloc_pkg::MAX_VOICES_DEF,
   parameter int TIME_BITS  = svalloc_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [svalloc_pkg::REQ_W-1:0]       req_type,
   input  logic [svalloc_pkg::CH_W-1:0]        req_music_channel,
   input  logic [svalloc_pkg::NOTE_W-1:0]      req_note_number,
   input  logic                                req_double_voice,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [svalloc_pkg::KIND_W-1:0]      rsp_event_kind,
   output logic [svalloc_pkg::VIDX_OUT_W-1:0]  rsp_voice_index,
   output logic [svalloc_pkg::CH_W-1:0]        rsp_voice_channel,
   output logic [svalloc_pkg::NOTE_W-1:0]      rsp_voice_note,
   output logic                                rsp_last_result,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [svalloc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [svalloc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [svalloc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int VIDX_W    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CNT_W     = $clog2(MAX_VOICES + 1);
   localparam int ACT_EXT_W = svalloc_pkg::ACT_W + 1;
   localparam logic [ACT_EXT_W-1:0] MAX_EXT = ACT_EXT_W'(MAX_VOICES);

   logic [svalloc_pkg::CH_W-1:0]  perc_ff, perc_in;
   logic [svalloc_pkg::ACT_W-1:0] active_ff, active_in;
   svalloc_pkg::reg_idx_type      reg_idx;
   logic                          csr_wr;
   logic [ACT_EXT_W-1:0]          act_ext;
   logic [ACT_EXT_W-1:0]          used_ext;
   logic [CNT_W-1:0]              used_count;

   svalloc_pkg::rb_ctl_type       rb_ctl;
   svalloc_pkg::rb_stat_type      rb_stat;
   svalloc_pkg::rsp_item_type     rb_item;
   svalloc_pkg::rsp_item_type     rsp_item;
   logic [VIDX_W-1:0]             tbl_rd_idx;
   logic [VIDX_W-1:0]             tbl_wr_idx;
   svalloc_pkg::slot_type         tbl_slot;
   logic [TIME_BITS-1:0]          tbl_start;
   svalloc_pkg::tbl_wr_type       tbl_wr_cmd;
   logic [TIME_BITS-1:0]          tbl_wr_start;

   assign csr_pready = 1'b1;
   assign reg_idx    = svalloc_pkg::reg_idx_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      perc_in    = perc_ff;
      active_in  = active_ff;
      csr_prdata = '0;
      unique case (reg_idx)
         svalloc_pkg::REG_PERC: begin
            csr_prdata = svalloc_pkg::CSR_DATA_W'(perc_ff);
            if (csr_wr) begin
               perc_in = csr_pwdata[svalloc_pkg::CH_W-1:0];
            end
         end
         svalloc_pkg::REG_ACTIVE: begin
            csr_prdata = svalloc_pkg::CSR_DATA_W'(active_ff);
            if (csr_wr) begin
               active_in = csr_pwdata[svalloc_pkg::ACT_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perc_ff   <= svalloc_pkg::PERC_RESET;
         active_ff <= svalloc_pkg::ACT_RESET;
      end else begin
         perc_ff   <= perc_in;
         active_ff <= active_in;
      end
   end

   // active count saturated to one..MAX_VOICES
   assign act_ext    = {1'b0, active_ff};
   assign used_ext   = (act_ext == '0) ? ACT_EXT_W'(1) :
                       (act_ext > MAX_EXT) ? MAX_EXT : act_ext;
   assign used_count = used_ext[CNT_W-1:0];

   svalloc_sequencer #(
      .MAX_VOICES (MAX_VOICES),
      .TIME_BITS  (TIME_BITS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_music_channel (req_music_channel),
      .req_note_number   (req_note_number),
      .req_double_voice  (req_double_voice),
      .perc_channel      (perc_ff),
      .used_count        (used_count),
      .rb_ctl            (rb_ctl),
      .rb_stat           (rb_stat),
      .rb_item           (rb_item),
      .tbl_rd_idx        (tbl_rd_idx),
      .tbl_slot          (tbl_slot),
      .tbl_start         (tbl_start),
      .tbl_wr_idx        (tbl_wr_idx),
      .tbl_wr_cmd        (tbl_wr_cmd),
      .tbl_wr_start      (tbl_wr_start)
   );

   svalloc_voice_table #(
      .MAX_VOICES (MAX_VOICES),
      .TIME_BITS  (TIME_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (tbl_rd_idx),
      .rd_slot  (tbl_slot),
      .rd_start (tbl_start),
      .wr_idx   (tbl_wr_idx),
      .wr_cmd   (tbl_wr_cmd),
      .wr_start (tbl_wr_start)
   );

   svalloc_result_buf u_rbuf (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rb_ctl),
      .item      (rb_item),
      .stat      (rb_stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .rsp_last  (rsp_last_result)
   );

   assign rsp_event_kind    = rsp_item.kind;
   assign rsp_voice_index   = rsp_item.vidx;
   assign rsp_voice_channel = rsp_item.ch;
   assign rsp_voice_note    = rsp_item.note;

endmodule

### sv/svalloc_voice_table.sv
// voice table: per-voice busy, owner, key, secondary mark and start time
`timescale 1ns / 1ps

module svalloc_voice_table #(
   parameter int MAX_VOICES = svalloc_pkg::MAX_VOICES_DEF,
   parameter int TIME_BITS  = svalloc_pkg::TIME_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] rd_idx,
   output svalloc_pkg::slot_type                            rd_slot,
   output logic [TIME_BITS-1:0]                             rd_start,
   input  logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] wr_idx,
   input  svalloc_pkg::tbl_wr_type                          wr_cmd,
   input  logic [TIME_BITS-1:0]                             wr_start
);

   logic                           busy_ff  [MAX_VOICES];
   logic [svalloc_pkg::CH_W-1:0]   owner_ff [MAX_VOICES];
   logic [svalloc_pkg::NOTE_W-1:0] key_ff   [MAX_VOICES];
   logic                           sec_ff   [MAX_VOICES];
   logic [TIME_BITS-1:0]           start_ff [MAX_VOICES];

   always_comb begin
      rd_slot.busy  = busy_ff[rd_idx];
      rd_slot.owner = owner_ff[rd_idx];
      rd_slot.key   = key_ff[rd_idx];
      rd_slot.sec   = sec_ff[rd_idx];
      rd_start      = start_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            busy_ff[i]  <= 1'b0;
            owner_ff[i] <= '0;
            key_ff[i]   <= '0;
            sec_ff[i]   <= 1'b0;
            start_ff[i] <= '0;
         end
      end else begin
         unique case (wr_cmd.op)
            svalloc_pkg::TBL_NOP: begin
            end
            svalloc_pkg::TBL_FREE: begin
               busy_ff[wr_idx] <= 1'b0;
            end
            svalloc_pkg::TBL_OCCUPY: begin
               busy_ff[wr_idx]  <= 1'b1;
               owner_ff[wr_idx] <= wr_cmd.owner;
               key_ff[wr_idx]   <= wr_cmd.key;
               sec_ff[wr_idx]   <= wr_cmd.sec;
               start_ff[wr_idx] <= wr_start;
            end
            svalloc_pkg::TBL_TOUCH: begin
               start_ff[wr_idx] <= wr_start;
            end
         endcase
      end
   end

endmodule

### sv/svalloc_slot_eval.sv
// shared compare unit: judges one voice slot against the current event
`timescale 1ns / 1ps

module svalloc_slot_eval #(
   parameter int TIME_BITS = svalloc_pkg::TIME_BITS_DEF
) (
   input  svalloc_pkg::slot_type     slot,
   input  logic [TIME_BITS-1:0]      start,
   input  svalloc_pkg::eval_ctx_type ctx,
   input  logic [TIME_BITS-1:0]      ref_time,
   output svalloc_pkg::eval_type     flags
);

   always_comb begin
      flags.free  = !slot.busy;
      // touch matches on channel alone, note off also needs the key
      flags.match = slot.busy && (slot.owner == ctx.ch) &&
                    (ctx.touch || (slot.key == ctx.note));
      flags.sec   = slot.sec;
      flags.older = (start < ref_time);
   end

endmodule

### sv/svalloc_result_buf.sv
// result buffer: one pending beat plus the output register, marks the last beat
`timescale 1ns / 1ps

module svalloc_result_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  svalloc_pkg::rb_ctl_type   ctl,
   input  svalloc_pkg::rsp_item_type item,
   output svalloc_pkg::rb_stat_type  stat,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output svalloc_pkg::rsp_item_type rsp_item,
   output logic                      rsp_last
);

   logic                           rsp_valid_ff, rsp_valid_in;
   svalloc_pkg::rsp_item_type      out_item_ff, out_item_in;
   logic                           out_last_ff, out_last_in;
   logic                           pend_valid_ff, pend_valid_in;
   svalloc_pkg::rsp_item_type      pend_item_ff, pend_item_in;
   logic [svalloc_pkg::RCNT_W-1:0] cnt_ff, cnt_in;
   logic                           out_free;
   logic                           capped;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign capped   = (cnt_ff >= svalloc_pkg::RCNT_W'(svalloc_pkg::MAX_RESULTS));

   always_comb begin
      stat.push_ok     = capped || !pend_valid_ff || out_free;
      stat.finish_done = !pend_valid_ff || out_free;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_item_in   = out_item_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_item_in  = pend_item_ff;
      cnt_in        = cnt_ff;
      // beats past the cap are dropped, the pending one keeps the last mark
      if (ctl.push && stat.push_ok && !capped) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            out_item_in  = pend_item_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_item_in  = item;
         cnt_in        = cnt_ff + 1'b1;
      end
      if (ctl.finish && stat.finish_done) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            out_item_in  = pend_item_ff;
            out_last_in  = 1'b1;
         end
         pend_valid_in = 1'b0;
         cnt_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      out_last_ff  <= out_last_in;
      pend_item_ff <= pend_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = out_item_ff;
   assign rsp_last  = out_last_ff;

endmodule

### sv/svalloc_sequencer.sv
// sequencer: walks the voice table one slot a cycle through the shared compare unit, unless a beat is stalled
`timescale 1ns / 1ps

module svalloc_sequencer #(
   parameter int MAX_VOICES = svalloc_pkg::MAX_VOICES_DEF,
   parameter int TIME_BITS  = svalloc_pkg::TIME_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [svalloc_pkg::REQ_W-1:0]          req_type,
   input  logic [svalloc_pkg::CH_W-1:0]           req_music_channel,
   input  logic [svalloc_pkg::NOTE_W-1:0]         req_note_number,
   input  logic                                   req_double_voice,
   input  logic [svalloc_pkg::CH_W-1:0]           perc_channel,
   input  logic [$clog2(MAX_VOICES + 1)-1:0]      used_count,
   output svalloc_pkg::rb_ctl_type                rb_ctl,
   input  svalloc_pkg::rb_stat_type               rb_stat,
   output svalloc_pkg::rsp_item_type              rb_item,
   output logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] tbl_rd_idx,
   input  svalloc_pkg::slot_type                  tbl_slot,
   input  logic [TIME_BITS-1:0]                   tbl_start,
   output logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] tbl_wr_idx,
   output svalloc_pkg::tbl_wr_type                tbl_wr_cmd,
   output logic [TIME_BITS-1:0]                   tbl_wr_start
);

   localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VOICES + 1);

   svalloc_pkg::state_type         state_ff, state_in;
   logic [VIDX_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [VIDX_W-1:0]              rover_ff, rover_in;
   logic [TIME_BITS-1:0]           now_ff, now_in;
   logic                           sec_phase_ff, sec_phase_in;
   svalloc_pkg::req_kind_type      rtype_ff, rtype_in;
   logic [svalloc_pkg::CH_W-1:0]   ch_ff, ch_in;
   logic [svalloc_pkg::NOTE_W-1:0] note_ff, note_in;
   logic                           dbl_ff, dbl_in;
   logic                           perc_ff, perc_in;
   logic [TIME_BITS-1:0]           oldest_ff, oldest_in;
   logic                           found_ff, found_in;
   logic [VIDX_W-1:0]              victim_ff, victim_in;

   svalloc_pkg::req_kind_type      req_kind;
   svalloc_pkg::eval_ctx_type      ctx;
   svalloc_pkg::eval_type          ev;
   logic                           accept;
   logic                           perc_req;
   logic                           perc_bad;
   logic [CNT_W-1:0]               idx_plus;
   logic [VIDX_W-1:0]              idx_next;
   logic                           idx_last;
   logic                           search_last;
   logic [VIDX_W-1:0]              rover_norm;
   logic                           found_next;
   logic                           hold;

   assign req_kind    = svalloc_pkg::req_kind_type'(req_type);
   assign req_ready   = (state_ff == svalloc_pkg::ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign perc_req    = (req_music_channel == perc_channel);
   assign perc_bad    = perc_req && ((req_note_number < svalloc_pkg::PERC_LOW) ||
                                     (req_note_number > svalloc_pkg::PERC_HIGH));
   assign idx_plus    = CNT_W'(idx_ff) + 1'b1;
   assign idx_last    = (idx_plus >= used_count);
   assign idx_next    = idx_last ? '0 : idx_plus[VIDX_W-1:0];
   assign search_last = ((cnt_ff + 1'b1) >= used_count);
   assign rover_norm  = (CNT_W'(rover_ff) >= used_count) ? '0 : rover_ff;
   assign found_next  = found_ff || ev.older;

   always_comb begin
      ctx.ch    = ch_ff;
      ctx.note  = note_ff;
      ctx.touch = (rtype_ff == svalloc_pkg::REQ_TOUCH);
   end

   svalloc_slot_eval #(
      .TIME_BITS (TIME_BITS)
   ) u_eval (
      .slot     (tbl_slot),
      .start    (tbl_start),
      .ctx      (ctx),
      .ref_time (oldest_ff),
      .flags    (ev)
   );

   assign tbl_rd_idx   = idx_ff;
   assign tbl_wr_idx   = idx_ff;
   assign tbl_wr_start = now_ff;

   // result beats toward the buffer
   always_comb begin
      rb_ctl       = '0;
      rb_item.kind = svalloc_pkg::EV_REFUSED;
      rb_item.vidx = svalloc_pkg::VIDX_OUT_W'(idx_ff);
      rb_item.ch   = tbl_slot.owner;
      rb_item.note = tbl_slot.key;
      unique case (state_ff)
         svalloc_pkg::ST_STEAL: begin
            if (ev.sec) begin
               rb_ctl.push  = 1'b1;
               rb_item.kind = svalloc_pkg::EV_STOLEN;
            end
         end
         svalloc_pkg::ST_KILL: begin
            rb_ctl.push  = 1'b1;
            rb_item.kind = svalloc_pkg::EV_STOLEN;
         end
         svalloc_pkg::ST_OCCUPY: begin
            rb_ctl.push  = 1'b1;
            rb_item.kind = sec_phase_ff ? svalloc_pkg::EV_SECONDARY : svalloc_pkg::EV_PRIMARY;
            rb_item.ch   = ch_ff;
            rb_item.note = note_ff;
         end
         svalloc_pkg::ST_MATCH: begin
            if (ev.match) begin
               rb_ctl.push  = 1'b1;
               rb_item.kind = ctx.touch ? svalloc_pkg::EV_TOUCHED : svalloc_pkg::EV_RELEASED;
            end
         end
         svalloc_pkg::ST_REFUSE: begin
            rb_ctl.push  = 1'b1;
            rb_item.vidx = '0;
            rb_item.ch   = ch_ff;
            rb_item.note = note_ff;
         end
         svalloc_pkg::ST_FLUSH: begin
            rb_ctl.finish = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign hold = rb_ctl.push && !rb_stat.push_ok;

   // datapath and table writes, frozen while a beat cannot be taken
   always_comb begin
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rover_in     = rover_ff;
      now_in       = now_ff;
      sec_phase_in = sec_phase_ff;
      rtype_in     = rtype_ff;
      ch_in        = ch_ff;
      note_in      = note_ff;
      dbl_in       = dbl_ff;
      perc_in      = perc_ff;
      oldest_in    = oldest_ff;
      found_in     = found_ff;
      victim_in    = victim_ff;
      tbl_wr_cmd.op    = svalloc_pkg::TBL_NOP;
      tbl_wr_cmd.owner = ch_ff;
      tbl_wr_cmd.key   = note_ff;
      tbl_wr_cmd.sec   = sec_phase_ff;
      unique case (state_ff)
         svalloc_pkg::ST_IDLE: begin
            if (accept) begin
               rtype_in     = req_kind;
               ch_in        = req_music_channel;
               note_in      = req_note_number;
               dbl_in       = req_double_voice;
               perc_in      = perc_req;
               sec_phase_in = 1'b0;
               cnt_in       = '0;
               idx_in       = (req_kind == svalloc_pkg::REQ_NOTE_ON) ? rover_norm : '0;
               if (req_kind == svalloc_pkg::REQ_TICK) begin
                  now_in = now_ff + TIME_BITS'(1);
               end
            end
         end
         svalloc_pkg::ST_SEARCH: begin
            rover_in = idx_next;
            if (!ev.free) begin
               idx_in = idx_next;
               cnt_in = cnt_ff + 1'b1;
               if (search_last) begin
                  // no free voice: prepare the steal scan from voice zero
                  idx_in    = '0;
                  oldest_in = now_ff;
                  found_in  = 1'b0;
               end
            end
         end
         svalloc_pkg::ST_STEAL: begin
            if (ev.sec) begin
               if (!hold) begin
                  tbl_wr_cmd.op = svalloc_pkg::TBL_FREE;
               end
            end else begin
               if (ev.older) begin
                  oldest_in = tbl_start;
                  victim_in = idx_ff;
                  found_in  = 1'b1;
               end
               if (!idx_last) begin
                  idx_in = idx_ff + 1'b1;
               end else if (found_next && !perc_ff) begin
                  idx_in = ev.older ? idx_ff : victim_ff;
               end
            end
         end
         svalloc_pkg::ST_KILL: begin
            if (!hold) begin
               tbl_wr_cmd.op = svalloc_pkg::TBL_FREE;
            end
         end
         svalloc_pkg::ST_OCCUPY: begin
            if (!hold) begin
               tbl_wr_cmd.op = svalloc_pkg::TBL_OCCUPY;
               if (!sec_phase_ff && dbl_ff) begin
                  sec_phase_in = 1'b1;
                  idx_in       = rover_ff;
                  cnt_in       = '0;
               end
            end
         end
         svalloc_pkg::ST_MATCH: begin
            if (!hold) begin
               if (ev.match) begin
                  tbl_wr_cmd.op = ctx.touch ? svalloc_pkg::TBL_TOUCH : svalloc_pkg::TBL_FREE;
               end
               if (!idx_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         svalloc_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  svalloc_pkg::REQ_NOTE_ON:
                     state_in = perc_bad ? svalloc_pkg::ST_REFUSE : svalloc_pkg::ST_SEARCH;
                  svalloc_pkg::REQ_NOTE_OFF, svalloc_pkg::REQ_TOUCH:
                     state_in = svalloc_pkg::ST_MATCH;
                  svalloc_pkg::REQ_TICK:
                     state_in = svalloc_pkg::ST_FLUSH;
               endcase
            end
         end
         svalloc_pkg::ST_SEARCH: begin
            if (ev.free) begin
               state_in = svalloc_pkg::ST_OCCUPY;
            end else if (search_last) begin
               state_in = sec_phase_ff ? svalloc_pkg::ST_FLUSH : svalloc_pkg::ST_STEAL;
            end
         end
         svalloc_pkg::ST_STEAL: begin
            if (ev.sec) begin
               if (!hold) begin
                  state_in = svalloc_pkg::ST_OCCUPY;
               end
            end else if (idx_last) begin
               state_in = (found_next && !perc_ff) ? svalloc_pkg::ST_KILL
                                                   : svalloc_pkg::ST_REFUSE;
            end
         end
         svalloc_pkg::ST_KILL: begin
            if (!hold) begin
               state_in = svalloc_pkg::ST_OCCUPY;
            end
         end
         svalloc_pkg::ST_OCCUPY: begin
            if (!hold) begin
               state_in = (!sec_phase_ff && dbl_ff) ? svalloc_pkg::ST_SEARCH
                                                    : svalloc_pkg::ST_FLUSH;
            end
         end
         svalloc_pkg::ST_MATCH: begin
            if (!hold && idx_last) begin
               state_in = svalloc_pkg::ST_FLUSH;
            end
         end
         svalloc_pkg::ST_REFUSE: begin
            if (!hold) begin
               state_in = svalloc_pkg::ST_FLUSH;
            end
         end
         svalloc_pkg::ST_FLUSH: begin
            if (rb_stat.finish_done) begin
               state_in = svalloc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svalloc_pkg::ST_IDLE;
         rover_ff <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rover_ff <= rover_in;
         now_ff   <= now_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      sec_phase_ff <= sec_phase_in;
      rtype_ff     <= rtype_in;
      ch_ff        <= ch_in;
      note_ff      <= note_in;
      dbl_ff       <= dbl_in;
      perc_ff      <= perc_in;
      oldest_ff    <= oldest_in;
      found_ff     <= found_in;
      victim_ff    <= victim_in;
   end

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != svalloc_pkg::ST_IDLE))
      else $error("accepted beat did not start a sequence");

   a_stall_freezes_state: assert property (@(posedge clock) disable iff (reset)
      hold |=> ($stable(state_ff) && $stable(idx_ff)))
      else $error("sequencer moved while a result beat was stalled");

   a_write_only_when_taken: assert property (@(posedge clock) disable iff (reset)
      (tbl_wr_cmd.op != svalloc_pkg::TBL_NOP) |-> !hold)
      else $error("table written while its result beat was stalled");

   a_scan_index_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == svalloc_pkg::ST_STEAL) || (state_ff == svalloc_pkg::ST_KILL) ||
       (state_ff == svalloc_pkg::ST_OCCUPY) || (state_ff == svalloc_pkg::ST_MATCH))
      |-> (CNT_W'(idx_ff) < used_count))
      else $error("voice index beyond active voice count");
`endif

endmodule
